[rtl/ssat_pkg.sv]
// Shared constants, types and constant tables for the staged saturator.
// No dependencies; every other file refers to it by scoped names.
package ssat_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int FRAC_BITS        = SAMPLE_BITS - 1;
    localparam int MAX_STAGES       = 10;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int TAB_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int TFRAC_BITS       = 30 - TAB_BITS;
    localparam int AMT_BITS         = 17;
    localparam int STG_BITS         = 4;
    localparam int IDX_BITS         = 2;
    localparam int Q30_BITS         = 31;
    localparam int MANT_BITS        = 24;
    localparam int EXP_BITS         = 5;
    localparam int SH_BITS          = 6;
    localparam int STAGE_LAT        = 6;
    localparam int LANE_LAT         = 2 + MAX_STAGES * STAGE_LAT;

    localparam logic [AMT_BITS-1:0]  ONE_Q16  = 17'h10000;
    localparam logic [Q30_BITS-1:0]  ONE_Q30  = 31'h40000000;
    localparam logic [31:0]          CUBIC_K  = 32'd1574821342;
    localparam logic [MANT_BITS-1:0] MANT_MAX = '1;
    localparam longint unsigned      HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_AMOUNT = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_STAGES = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_FUNC   = 2'd2;

    // curve codes
    localparam logic FN_SINE  = 1'b0;
    localparam logic FN_CUBIC = 1'b1;

    typedef logic [Q30_BITS-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];
    typedef logic [AMT_BITS-1:0] loss_tab_t [0:MAX_STAGES];

    // derived settings handed to the lanes
    typedef struct packed {
        logic [AMT_BITS-1:0]  drive;
        logic [MANT_BITS-1:0] recip;
        logic [SH_BITS-1:0]   shift;
        logic [AMT_BITS-1:0]  gain;
        logic [STG_BITS-1:0]  stages;
        logic                 fn;
    } ssat_cfg_t;

    // elaboration-time shift-subtract quotient for the table builders
    function automatic longint unsigned const_div(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // quarter-wave sine, truncated integer Taylor series, Q1.30
    function automatic sine_tab_t build_sine();
        sine_tab_t         tab;
        longint unsigned   th;
        longint unsigned   term;
        longint            sm;
        int                k;
        int                n;
        for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
            th   = (HALF_PI_Q30 * longint'(k)) >> TAB_BITS;
            term = th;
            sm   = longint'(th);
            for (n = 1; n <= 9; n++) begin
                term = (term * th) >> 30;
                term = (term * th) >> 30;
                term = const_div(term, longint'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    sm = sm - longint'(term);
                else
                    sm = sm + longint'(term);
            end
            if (sm < 0)
                sm = 0;
            if (sm > longint'(ONE_Q30))
                sm = longint'(ONE_Q30);
            tab[k] = Q30_BITS'(sm);
        end
        tab[SINE_TABLE_DEPTH] = ONE_Q30;
        return tab;
    endfunction

    // floor(65536*(n-1)/n) by stage count
    function automatic loss_tab_t build_loss();
        loss_tab_t tab;
        int        n;
        tab[0] = '0;
        for (n = 1; n <= MAX_STAGES; n++)
            tab[n] = AMT_BITS'(const_div(64'd65536 * longint'(n - 1), longint'(n)));
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();
    localparam loss_tab_t LOSS_TAB = build_loss();

endpackage

[rtl/ssat_if.sv]
// Handshake channels of the saturator: sample frames in and out, register writes.
// Depends on ssat_pkg for the widths.
interface ssat_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ssat_pkg::SAMPLE_BITS-1:0] left_in;
    logic signed [ssat_pkg::SAMPLE_BITS-1:0] right_in;
    modport source (output valid, left_in, right_in, input ready);
    modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface ssat_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ssat_pkg::SAMPLE_BITS-1:0] left_out;
    logic signed [ssat_pkg::SAMPLE_BITS-1:0] right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface ssat_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ssat_pkg::IDX_BITS-1:0]       index;
    logic [ssat_pkg::AMT_BITS-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ssat_shape.sv]
// Three-register curve evaluator: sine table interpolation or cubic polynomial.
// Depends on ssat_pkg (sine table, cubic constant).
module ssat_shape (
    input  logic                          clk,
    input  logic                          en,
    input  logic                          fn,
    input  logic [ssat_pkg::Q30_BITS-1:0] t,
    output logic [ssat_pkg::Q30_BITS-1:0] c
);

    logic [ssat_pkg::Q30_BITS-1:0]   p;
    logic [ssat_pkg::TAB_BITS-1:0]   idx;
    logic [ssat_pkg::Q30_BITS-1:0]   lo;
    logic [ssat_pkg::Q30_BITS-1:0]   hi;
    logic [ssat_pkg::Q30_BITS-1:0]   d;
    logic [2*ssat_pkg::Q30_BITS-1:0] sq_prod;
    logic [2*ssat_pkg::Q30_BITS:0]   cub_prod;
    logic [64:0]                     k3_prod;
    logic [ssat_pkg::Q30_BITS+ssat_pkg::TFRAC_BITS-1:0] ip_prod;

    logic [ssat_pkg::Q30_BITS-1:0]   t1_reg, t2_reg, t3_reg;
    logic [31:0]                     sq_reg;
    logic [32:0]                     cub_reg;
    logic [31:0]                     k3_reg;
    logic [ssat_pkg::Q30_BITS-1:0]   lo1_reg, lo2_reg, sf_reg;
    logic [ssat_pkg::Q30_BITS-1:0]   d1_reg;
    logic [ssat_pkg::TFRAC_BITS-1:0] fr1_reg;
    logic [ssat_pkg::Q30_BITS-1:0]   ip_reg;

    // table lookup, phase saturated to a quarter turn
    always_comb
    begin
        p   = t[30] ? ssat_pkg::ONE_Q30 : t;
        idx = p[29 -: ssat_pkg::TAB_BITS];
        if (p[30])
        begin
            lo = ssat_pkg::ONE_Q30;
            hi = ssat_pkg::ONE_Q30;
        end
        else
        begin
            lo = ssat_pkg::SINE_TAB[idx];
            hi = ssat_pkg::SINE_TAB[{1'b0, idx} + 1'b1];
        end
        d = (hi > lo) ? (hi - lo) : '0;
    end

    assign sq_prod  = t * t;
    assign cub_prod = sq_reg * t1_reg;
    assign ip_prod  = d1_reg * fr1_reg;
    assign k3_prod  = cub_reg * ssat_pkg::CUBIC_K;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t;
            sq_reg  <= sq_prod[61:30];
            lo1_reg <= lo;
            d1_reg  <= d;
            fr1_reg <= p[ssat_pkg::TFRAC_BITS-1:0];

            t2_reg  <= t1_reg;
            cub_reg <= cub_prod[62:30];
            lo2_reg <= lo1_reg;
            ip_reg  <= ip_prod[ssat_pkg::TFRAC_BITS +: ssat_pkg::Q30_BITS];

            t3_reg  <= t2_reg;
            k3_reg  <= k3_prod[63:32];
            sf_reg  <= lo2_reg + ip_reg;
        end
    end

    // cubic stays nonnegative
    always_comb
    begin
        if (fn == ssat_pkg::FN_CUBIC)
            c = ({1'b0, t3_reg} > k3_reg) ? ssat_pkg::Q30_BITS'({1'b0, t3_reg} - k3_reg) : '0;
        else
            c = sf_reg;
    end

endmodule

[rtl/ssat_stage.sv]
// One application of the curve to a magnitude, six registers deep.
// Depends on ssat_pkg and ssat_shape.
module ssat_stage (
    input  logic                             clk,
    input  logic                             en,
    input  logic                             active,
    input  ssat_pkg::ssat_cfg_t              cfg,
    input  logic [ssat_pkg::SAMPLE_BITS-1:0] m_in,
    input  logic [ssat_pkg::SAMPLE_BITS-1:0] side_in,
    output logic [ssat_pkg::SAMPLE_BITS-1:0] m_out,
    output logic [ssat_pkg::SAMPLE_BITS-1:0] side_out
);

    localparam int CR_BITS = ssat_pkg::Q30_BITS + ssat_pkg::MANT_BITS;

    logic [ssat_pkg::SAMPLE_BITS+ssat_pkg::AMT_BITS-1:0] t_prod;
    logic [ssat_pkg::Q30_BITS-1:0]    t_reg;
    logic [ssat_pkg::Q30_BITS-1:0]    c;
    logic [CR_BITS-1:0]               cr_reg;
    logic [CR_BITS-1:0]               shifted;
    logic [ssat_pkg::SAMPLE_BITS-1:0] m_reg;
    logic [ssat_pkg::SAMPLE_BITS-1:0] m_d_reg    [0:ssat_pkg::STAGE_LAT-1];
    logic [ssat_pkg::SAMPLE_BITS-1:0] side_d_reg [0:ssat_pkg::STAGE_LAT-1];

    assign t_prod = m_in * cfg.drive;

    ssat_shape u_shape (
        .clk (clk),
        .en  (en),
        .fn  (cfg.fn),
        .t   (t_reg),
        .c   (c)
    );

    assign shifted = cr_reg >> cfg.shift;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t_prod[ssat_pkg::FRAC_BITS-14 +: ssat_pkg::Q30_BITS];
            cr_reg <= c * cfg.recip;
            // clamp between stages
            if (|shifted[CR_BITS-1:ssat_pkg::SAMPLE_BITS])
                m_reg <= '1;
            else
                m_reg <= shifted[ssat_pkg::SAMPLE_BITS-1:0];
            m_d_reg[0]    <= m_in;
            side_d_reg[0] <= side_in;
            for (int i = 1; i < ssat_pkg::STAGE_LAT; i++)
            begin
                m_d_reg[i]    <= m_d_reg[i-1];
                side_d_reg[i] <= side_d_reg[i-1];
            end
        end
    end

    // stages past the count pass the magnitude on
    assign m_out    = active ? m_reg : m_d_reg[ssat_pkg::STAGE_LAT-1];
    assign side_out = side_d_reg[ssat_pkg::STAGE_LAT-1];

endmodule

[rtl/ssat_lane.sv]
// One channel: sign split, chain of curve stages, output gain and clip.
// Depends on ssat_pkg and ssat_stage.
module ssat_lane (
    input  logic                             clk,
    input  logic                             en,
    input  ssat_pkg::ssat_cfg_t              cfg,
    input  logic [ssat_pkg::SAMPLE_BITS-1:0] sample,
    output logic [ssat_pkg::SAMPLE_BITS-1:0] result
);

    localparam int O_BITS = ssat_pkg::SAMPLE_BITS + 1;

    logic [ssat_pkg::SAMPLE_BITS-1:0] raw0_reg;
    logic [ssat_pkg::SAMPLE_BITS-1:0] mag0_reg;
    logic [ssat_pkg::SAMPLE_BITS-1:0] m_w    [0:ssat_pkg::MAX_STAGES];
    logic [ssat_pkg::SAMPLE_BITS-1:0] side_w [0:ssat_pkg::MAX_STAGES];
    logic [ssat_pkg::SAMPLE_BITS+ssat_pkg::AMT_BITS-1:0] g_prod;
    logic [O_BITS-1:0]                og_reg;
    logic [ssat_pkg::SAMPLE_BITS-1:0] rawg_reg;
    logic [O_BITS-1:0]                neg_o;

    // magnitude of the input word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw0_reg <= sample;
            mag0_reg <= sample[ssat_pkg::FRAC_BITS] ? (~sample + 1'b1) : sample;
        end
    end

    assign m_w[0]    = mag0_reg;
    assign side_w[0] = raw0_reg;

    for (genvar j = 0; j < ssat_pkg::MAX_STAGES; j++)
    begin : g_stage
        ssat_stage u_stage (
            .clk      (clk),
            .en       (en),
            .active   (int'(cfg.stages) > j),
            .cfg      (cfg),
            .m_in     (m_w[j]),
            .side_in  (side_w[j]),
            .m_out    (m_w[j+1]),
            .side_out (side_w[j+1])
        );
    end

    assign g_prod = m_w[ssat_pkg::MAX_STAGES] * cfg.gain;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            og_reg   <= g_prod[16 +: O_BITS];
            rawg_reg <= side_w[ssat_pkg::MAX_STAGES];
        end
    end

    // sign back on, clip to full scale; zero drive passes the input
    always_comb
    begin
        neg_o = (O_BITS'(1) << ssat_pkg::SAMPLE_BITS) - og_reg;
        if (cfg.drive == '0)
            result = rawg_reg;
        else if (rawg_reg[ssat_pkg::FRAC_BITS])
        begin
            if (og_reg > (O_BITS'(1) << ssat_pkg::FRAC_BITS))
                result = {1'b1, {ssat_pkg::FRAC_BITS{1'b0}}};
            else
                result = neg_o[ssat_pkg::SAMPLE_BITS-1:0];
        end
        else if (og_reg > ((O_BITS'(1) << ssat_pkg::FRAC_BITS) - 1'b1))
            result = {1'b0, {ssat_pkg::FRAC_BITS{1'b1}}};
        else
            result = og_reg[ssat_pkg::SAMPLE_BITS-1:0];
    end

endmodule

[rtl/ssat_derive.sv]
// Register file and settings sequencer: drive clamp, gain, curve value at
// full drive and its reciprocal by restoring division. Depends on ssat_pkg,
// ssat_shape and ssat_if.
module ssat_derive (
    input  logic                clk,
    input  logic                rst_n,
    ssat_cfg_if.sink            cfg,
    output logic                busy,
    output ssat_pkg::ssat_cfg_t settings
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_SHAPE = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [4:0] DIV_STEPS = 5'(ssat_pkg::MANT_BITS + 1);

    logic [2:0]                          state_reg;
    logic [ssat_pkg::AMT_BITS-1:0]       amt_reg;
    logic [ssat_pkg::STG_BITS-1:0]       stg_reg;
    logic                                fn_reg;
    logic [ssat_pkg::AMT_BITS-1:0]       drive_reg;
    logic [ssat_pkg::STG_BITS-1:0]       nst_reg;
    logic [ssat_pkg::AMT_BITS-1:0]       gain_reg;
    logic [ssat_pkg::MANT_BITS-1:0]      recip_reg;
    logic [ssat_pkg::EXP_BITS-1:0]       exp_reg;
    logic [ssat_pkg::Q30_BITS-1:0]       t_reg;
    logic [2*ssat_pkg::AMT_BITS-1:0]     gp_reg;
    logic [ssat_pkg::Q30_BITS-1:0]       f_reg;
    logic [31:0]                         rem_reg;
    logic [ssat_pkg::MANT_BITS:0]        quo_reg;
    logic [4:0]                          cnt_reg;

    logic                                wr;
    logic [ssat_pkg::AMT_BITS-1:0]       a_clamp;
    logic [ssat_pkg::STG_BITS-1:0]       n_clamp;
    logic [ssat_pkg::Q30_BITS-1:0]       c;
    logic [ssat_pkg::EXP_BITS-1:0]       lead;
    logic                                fits;
    logic [31:0]                         rem_sub;
    logic [ssat_pkg::MANT_BITS:0]        quo_next;

    assign wr        = cfg.valid && cfg.ready;
    assign cfg.ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    assign a_clamp = (amt_reg > ssat_pkg::ONE_Q16) ? ssat_pkg::ONE_Q16 : amt_reg;

    always_comb
    begin
        if (stg_reg == '0)
            n_clamp = 4'd1;
        else if (int'(stg_reg) > ssat_pkg::MAX_STAGES)
            n_clamp = ssat_pkg::STG_BITS'(ssat_pkg::MAX_STAGES);
        else
            n_clamp = stg_reg;
    end

    // curve at full drive
    ssat_shape u_shape (
        .clk (clk),
        .en  (1'b1),
        .fn  (fn_reg),
        .t   (t_reg),
        .c   (c)
    );

    // top set bit of the curve value
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < ssat_pkg::Q30_BITS; i++)
            if (f_reg[i])
                lead = ssat_pkg::EXP_BITS'(i);
    end

    // one quotient bit per step
    assign fits     = (rem_reg >= {1'b0, f_reg});
    assign rem_sub  = fits ? (rem_reg - {1'b0, f_reg}) : rem_reg;
    assign quo_next = {quo_reg[ssat_pkg::MANT_BITS-1:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            amt_reg   <= '0;
            stg_reg   <= 4'd1;
            fn_reg    <= ssat_pkg::FN_CUBIC;
            drive_reg <= '0;
            nst_reg   <= 4'd1;
            gain_reg  <= ssat_pkg::ONE_Q16;
            recip_reg <= '0;
            exp_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (wr)
                    begin
                        case (cfg.index)
                            ssat_pkg::REG_AMOUNT: amt_reg <= cfg.data;
                            ssat_pkg::REG_STAGES: stg_reg <= cfg.data[ssat_pkg::STG_BITS-1:0];
                            ssat_pkg::REG_FUNC:   fn_reg  <= cfg.data[0];
                            default: ;
                        endcase
                        if (cfg.index inside {ssat_pkg::REG_AMOUNT, ssat_pkg::REG_STAGES,
                                              ssat_pkg::REG_FUNC})
                            state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    drive_reg <= a_clamp;
                    nst_reg   <= n_clamp;
                    cnt_reg   <= '0;
                    state_reg <= ST_SHAPE;
                end
                ST_SHAPE:
                begin
                    gain_reg <= ssat_pkg::ONE_Q16 - {1'b0, gp_reg[31:16]};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd3)
                        state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    if (drive_reg == '0)
                    begin
                        recip_reg <= '0;
                        exp_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else if (f_reg == '0)
                    begin
                        recip_reg <= ssat_pkg::MANT_MAX;
                        exp_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        exp_reg   <= lead;
                        cnt_reg   <= DIV_STEPS;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 5'd1)
                    begin
                        recip_reg <= quo_next[ssat_pkg::MANT_BITS] ? ssat_pkg::MANT_MAX :
                                     quo_next[ssat_pkg::MANT_BITS-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath work registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            t_reg  <= {a_clamp, 14'b0};
            gp_reg <= ssat_pkg::LOSS_TAB[n_clamp] * a_clamp;
        end
        if (state_reg == ST_SHAPE && cnt_reg == 5'd3)
            f_reg <= c;
        if (state_reg == ST_NORM)
        begin
            rem_reg <= 32'(1) << lead;
            quo_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= {rem_sub[30:0], 1'b0};
            quo_reg <= quo_next;
        end
    end

    assign settings.drive  = drive_reg;
    assign settings.recip  = recip_reg;
    assign settings.shift  = ssat_pkg::SH_BITS'(exp_reg) + 1'b1;
    assign settings.gain   = gain_reg;
    assign settings.stages = nst_reg;
    assign settings.fn     = fn_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("division step count ran out");

    a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && (cfg.index == ssat_pkg::REG_AMOUNT || cfg.index == ssat_pkg::REG_STAGES ||
                cfg.index == ssat_pkg::REG_FUNC)) |=> busy)
        else $error("register write did not start derivation");

endmodule

[rtl/stereo_staged_saturator_core.sv]
// One frame per cycle while the output word is taken and no derivation runs, set by
// the fully unrolled stage chain (10 stages of 6 registers) in each lane.
// After a write to the amount, stages or curve register, settings derivation (and, at
// nonzero drive and curve value, the reciprocal divider) holds off frames and further writes.
// Reset: amount 0 (bypass), 1 stage, cubic curve, gain 1.0, pipeline empty.
// Depends on ssat_pkg, ssat_if, ssat_derive and ssat_lane.
module stereo_staged_saturator_core (
    input  logic        clk,
    input  logic        rst_n,
    ssat_in_if.sink     frame_in,
    ssat_out_if.source  frame_out,
    ssat_cfg_if.sink    cfg
);

    logic                              busy;
    ssat_pkg::ssat_cfg_t               settings;
    logic                              en;
    logic                              accept;
    logic [ssat_pkg::LANE_LAT-1:0]     vld_pipe_reg;
    logic                              out_valid_reg;
    logic [ssat_pkg::SAMPLE_BITS-1:0]  left_res, right_res;
    logic [ssat_pkg::SAMPLE_BITS-1:0]  left_reg, right_reg;

    ssat_derive u_derive (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .busy     (busy),
        .settings (settings)
    );

    // whole pipeline moves unless the output word is held
    assign en             = !out_valid_reg || frame_out.ready;
    assign frame_in.ready = en && !busy;
    assign accept         = frame_in.valid && frame_in.ready;

    ssat_lane u_left (
        .clk    (clk),
        .en     (en),
        .cfg    (settings),
        .sample (frame_in.left_in),
        .result (left_res)
    );

    ssat_lane u_right (
        .clk    (clk),
        .en     (en),
        .cfg    (settings),
        .sample (frame_in.right_in),
        .result (right_res)
    );

    // valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_pipe_reg  <= {vld_pipe_reg[ssat_pkg::LANE_LAT-2:0], accept};
            out_valid_reg <= vld_pipe_reg[ssat_pkg::LANE_LAT-1];
        end
    end

    // merge both lanes into the output word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_res;
            right_reg <= right_res;
        end
    end

    assign frame_out.valid     = out_valid_reg;
    assign frame_out.left_out  = left_reg;
    assign frame_out.right_out = right_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        frame_in.ready |-> !busy)
        else $error("frame taken during derivation");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_pipe_reg))
        else $error("pipeline moved while output held");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_pipe_reg[ssat_pkg::LANE_LAT-1]))
        else $error("output word without a frame behind it");

endmodule
